[design/nclp_pkg.sv]
package nclp_pkg;

    // Count saturation width and the fixed field widths
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int SCALE_W         = 24;
    localparam int TOTAL_W         = 32;
    localparam int ACT_W           = 48;
    localparam int KIND_W          = 3;
    localparam int IN_DATA_W       = 8;
    localparam int OUT_DATA_W      = 3 * TOTAL_W + 2 * ACT_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd42336;

    typedef logic [KIND_W-1:0]  report_kind_t;
    typedef logic [TOTAL_W-1:0] total_t;
    typedef logic [ACT_W-1:0]   activity_t;

    // Report kinds
    localparam report_kind_t RK_HELLO    = 3'd0;
    localparam report_kind_t RK_NODE_ONE = 3'd1;
    localparam report_kind_t RK_NODE_TWO = 3'd2;
    localparam report_kind_t RK_UNKNOWN  = 3'd3;
    localparam report_kind_t RK_NO_SEP   = 3'd4;
    localparam report_kind_t RK_NO_KEY   = 3'd5;
    localparam report_kind_t RK_WINDOW   = 3'd6;

    // Input item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Number scanner phases
    localparam logic [1:0] NUM_START = 2'd0;
    localparam logic [1:0] NUM_SIGN  = 2'd1;
    localparam logic [1:0] NUM_DIGIT = 2'd2;
    localparam logic [1:0] NUM_DONE  = 2'd3;

    // Key match progress
    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_C     = 2'd1;
    localparam logic [1:0] KEY_FOUND = 2'd2;

    localparam logic [2:0] HELLO_FOUND = 3'd5;

    // Character codes
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_ONE   = 8'd49;
    localparam logic [7:0] CH_TWO   = 8'd50;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_EQUAL = 8'd61;
    localparam logic [7:0] CH_C     = 8'd67;
    localparam logic [7:0] CH_E     = 8'd69;
    localparam logic [7:0] CH_H     = 8'd72;
    localparam logic [7:0] CH_L     = 8'd76;
    localparam logic [7:0] CH_O     = 8'd79;

    // Expected character at each position of the handshake word
    function automatic logic [7:0] hello_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = CH_H;
            3'd1:    ch = CH_E;
            3'd2:    ch = CH_L;
            3'd3:    ch = CH_L;
            3'd4:    ch = CH_O;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

[design/node_count_line_parser.sv]
// Node count line parser.
//
// Input stream (s_axis_*): one item per accepted handshake. tuser selects the
// kind: a received serial byte in tdata[7:0], or the end of an integration
// window. Bytes build text lines; CR or LF closes a line and may produce one
// result. A window end always produces one report with both totals and their
// activities, then clears the totals.
// Output stream (m_axis_*): tuser carries the report kind, tdata the counts,
// totals and activities.
// Configuration: cfg_we writes cfg_wdata into the activity scale; write it
// only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls. A result passes the
// input register, the parse stage and the multiply stage, each stage ending in a
// register. The two 32x24 multipliers of the window report set the last stage.
// Reset clears the line state, both totals and all stage valid flags, and
// loads the default scale. When the receiver stalls, the stages fill up and
// s_axis_tready drops once all three registers hold items; nothing is lost.
module node_count_line_parser #(
    parameter int COUNT_WIDTH = nclp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [nclp_pkg::SCALE_W-1:0]         cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [nclp_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
    input  logic                                 s_axis_tuser,  // [0] kind
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [31:0] parsed_count, [63:32] total_one, [95:64] total_two,
    // [143:96] activity_one, [191:144] activity_two
    output logic [nclp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic [nclp_pkg::KIND_W-1:0]          m_axis_tuser   // [2:0] report_kind
);
    import nclp_pkg::*;

    localparam int NEG_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;
    localparam int SUM_W = COUNT_WIDTH + 4;
    localparam int PROD_W = TOTAL_W + SCALE_W;

    localparam logic [COUNT_WIDTH-1:0] LIMIT = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // ---------------- configuration ----------------
    logic [SCALE_W-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            scale_reg <= cfg_wdata;
        end
    end

    // ---------------- stage handshakes ----------------
    logic in_valid_reg;
    logic in_kind_reg;
    logic [7:0] in_byte_reg;
    logic mid_valid_reg;
    logic out_valid_reg;
    logic out_ready;
    logic mid_ready;
    logic in_ready;
    logic b_fire;

    // Each stage moves when it is empty or its successor moves
    assign out_ready = !out_valid_reg || m_axis_tready;
    assign mid_ready = !mid_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || mid_ready;
    assign b_fire    = in_valid_reg && mid_ready;

    assign s_axis_tready = in_ready;

    // ---------------- input register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // ---------------- parse stage ----------------
    logic nonblank_seen_reg, nonblank_seen_next;
    logic semicolon_seen_reg, semicolon_seen_next;
    logic id_has_one_reg, id_has_one_next;
    logic id_has_two_reg, id_has_two_next;
    logic [2:0] hello_match_reg, hello_match_next;
    logic [1:0] key_match_reg, key_match_next;
    logic [1:0] number_phase_reg, number_phase_next;
    logic number_negative_reg, number_negative_next;
    logic [COUNT_WIDTH-1:0] number_magnitude_reg, number_magnitude_next;
    total_t accum_one_reg, accum_one_next;
    total_t accum_two_reg, accum_two_next;

    logic has_result;
    report_kind_t rk;
    total_t count_value;

    logic [7:0] ch;
    logic is_digit;
    logic is_printable;
    logic is_eol;
    logic [3:0] digit_value;
    logic [SUM_W-1:0] mag_ext;
    logic [SUM_W-1:0] mag_sum;
    logic [COUNT_WIDTH-1:0] mag_grown;
    logic [NEG_W-1:0] mag_wide;
    logic [NEG_W-1:0] mag_neg;
    logic [COUNT_WIDTH-1:0] mag_pos;
    total_t final_count;

    assign ch           = in_byte_reg;
    assign is_digit     = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_printable = (ch >= CH_SPACE) && (ch <= CH_TILDE);
    assign is_eol       = (ch == CH_LF) || (ch == CH_CR);
    assign digit_value  = ch[3:0];

    // Decimal accumulate: times ten plus the digit, clamped to the limit
    assign mag_ext   = SUM_W'(number_magnitude_reg);
    assign mag_sum   = (mag_ext << 3) + (mag_ext << 1) + SUM_W'(digit_value);
    assign mag_grown = (mag_sum > SUM_W'(LIMIT)) ? LIMIT : mag_sum[COUNT_WIDTH-1:0];

    // Signed result: negate the magnitude, or clamp it to the positive maximum
    assign mag_wide = NEG_W'(number_magnitude_reg);
    assign mag_neg  = '0 - mag_wide;
    assign mag_pos  = (number_magnitude_reg == LIMIT) ? (LIMIT - 1'b1) : number_magnitude_reg;

    always_comb
    begin
        logic [NEG_W-1:0] pos_wide;
        pos_wide = NEG_W'(mag_pos);
        if (number_negative_reg)
        begin
            final_count = mag_neg[TOTAL_W-1:0];
        end
        else
        begin
            final_count = pos_wide[TOTAL_W-1:0];
        end
    end

    always_comb
    begin
        logic clear_line;
        clear_line            = 1'b0;
        nonblank_seen_next    = nonblank_seen_reg;
        semicolon_seen_next   = semicolon_seen_reg;
        id_has_one_next       = id_has_one_reg;
        id_has_two_next       = id_has_two_reg;
        hello_match_next      = hello_match_reg;
        key_match_next        = key_match_reg;
        number_phase_next     = number_phase_reg;
        number_negative_next  = number_negative_reg;
        number_magnitude_next = number_magnitude_reg;
        accum_one_next        = accum_one_reg;
        accum_two_next        = accum_two_reg;
        has_result            = 1'b0;
        rk                    = RK_WINDOW;
        count_value           = '0;

        if (in_kind_reg == KIND_TICK)
        begin
            // Report the totals as they stand, then clear them
            has_result     = 1'b1;
            rk             = RK_WINDOW;
            accum_one_next = '0;
            accum_two_next = '0;
        end
        else if (is_eol)
        begin
            clear_line = 1'b1;
            if (nonblank_seen_reg)
            begin
                has_result = 1'b1;
                if ((hello_match_reg == HELLO_FOUND) && semicolon_seen_reg)
                begin
                    rk = RK_HELLO;
                end
                else if (!semicolon_seen_reg)
                begin
                    rk = RK_NO_SEP;
                end
                else if (key_match_reg != KEY_FOUND)
                begin
                    rk = RK_NO_KEY;
                end
                else
                begin
                    count_value = final_count;
                    if (id_has_one_reg)
                    begin
                        accum_one_next = accum_one_reg + final_count;
                        rk = RK_NODE_ONE;
                    end
                    else if (id_has_two_reg)
                    begin
                        accum_two_next = accum_two_reg + final_count;
                        rk = RK_NODE_TWO;
                    end
                    else
                    begin
                        rk = RK_UNKNOWN;
                    end
                end
            end
        end
        else if (is_printable)
        begin
            if (ch != CH_SPACE)
            begin
                nonblank_seen_next = 1'b1;
            end

            if (hello_match_reg < HELLO_FOUND)
            begin
                if (ch == hello_char(hello_match_reg))
                begin
                    hello_match_next = hello_match_reg + 3'd1;
                end
                else
                begin
                    hello_match_next = (ch == CH_H) ? 3'd1 : 3'd0;
                end
            end

            if (!semicolon_seen_reg)
            begin
                // Node id part: look for the separator and the id digits
                if (ch == CH_SEMI)
                begin
                    semicolon_seen_next = 1'b1;
                end
                else if (ch == CH_ONE)
                begin
                    id_has_one_next = 1'b1;
                end
                else if (ch == CH_TWO)
                begin
                    id_has_two_next = 1'b1;
                end
            end
            else if (key_match_reg == KEY_FOUND)
            begin
                case (number_phase_reg)
                    NUM_START:
                    begin
                        if (ch == CH_SPACE)
                        begin
                            number_phase_next = NUM_START;
                        end
                        else if ((ch == CH_PLUS) || (ch == CH_MINUS))
                        begin
                            number_negative_next = (ch == CH_MINUS);
                            number_phase_next    = NUM_SIGN;
                        end
                        else if (is_digit)
                        begin
                            number_magnitude_next = COUNT_WIDTH'(digit_value);
                            number_phase_next     = NUM_DIGIT;
                        end
                        else
                        begin
                            number_phase_next = NUM_DONE;
                        end
                    end
                    NUM_SIGN, NUM_DIGIT:
                    begin
                        if (is_digit)
                        begin
                            number_magnitude_next = mag_grown;
                            number_phase_next     = NUM_DIGIT;
                        end
                        else
                        begin
                            number_phase_next = NUM_DONE;
                        end
                    end
                    default:
                    begin
                        number_phase_next = NUM_DONE;
                    end
                endcase
            end
            else if ((key_match_reg == KEY_C) && (ch == CH_EQUAL))
            begin
                key_match_next = KEY_FOUND;
            end
            else
            begin
                key_match_next = (ch == CH_C) ? KEY_C : KEY_NONE;
            end
        end

        if (clear_line)
        begin
            nonblank_seen_next    = 1'b0;
            semicolon_seen_next   = 1'b0;
            id_has_one_next       = 1'b0;
            id_has_two_next       = 1'b0;
            hello_match_next      = 3'd0;
            key_match_next        = KEY_NONE;
            number_phase_next     = NUM_START;
            number_negative_next  = 1'b0;
            number_magnitude_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonblank_seen_reg    <= 1'b0;
            semicolon_seen_reg   <= 1'b0;
            id_has_one_reg       <= 1'b0;
            id_has_two_reg       <= 1'b0;
            hello_match_reg      <= 3'd0;
            key_match_reg        <= KEY_NONE;
            number_phase_reg     <= NUM_START;
            number_negative_reg  <= 1'b0;
            number_magnitude_reg <= '0;
            accum_one_reg        <= '0;
            accum_two_reg        <= '0;
        end
        else if (b_fire)
        begin
            nonblank_seen_reg    <= nonblank_seen_next;
            semicolon_seen_reg   <= semicolon_seen_next;
            id_has_one_reg       <= id_has_one_next;
            id_has_two_reg       <= id_has_two_next;
            hello_match_reg      <= hello_match_next;
            key_match_reg        <= key_match_next;
            number_phase_reg     <= number_phase_next;
            number_negative_reg  <= number_negative_next;
            number_magnitude_reg <= number_magnitude_next;
            accum_one_reg        <= accum_one_next;
            accum_two_reg        <= accum_two_next;
        end
    end

    // ---------------- middle register ----------------
    report_kind_t mid_kind_reg;
    total_t mid_count_reg;
    total_t mid_total_one_reg;
    total_t mid_total_two_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
        end
        else if (mid_ready)
        begin
            mid_valid_reg <= in_valid_reg && has_result;
        end
    end

    // Window reports carry the totals before clearing, line results after update
    always_ff @(posedge clk)
    begin
        if (b_fire && has_result)
        begin
            mid_kind_reg      <= rk;
            mid_count_reg     <= count_value;
            mid_total_one_reg <= (rk == RK_WINDOW) ? accum_one_reg : accum_one_next;
            mid_total_two_reg <= (rk == RK_WINDOW) ? accum_two_reg : accum_two_next;
        end
    end

    // ---------------- multiply stage ----------------
    logic [PROD_W-1:0] prod_one;
    logic [PROD_W-1:0] prod_two;
    activity_t act_one;
    activity_t act_two;

    assign prod_one = PROD_W'(mid_total_one_reg) * PROD_W'(scale_reg);
    assign prod_two = PROD_W'(mid_total_two_reg) * PROD_W'(scale_reg);

    always_comb
    begin
        act_one = '0;
        act_two = '0;
        if (mid_kind_reg == RK_WINDOW)
        begin
            act_one = (|prod_one[PROD_W-1:ACT_W]) ? '1 : prod_one[ACT_W-1:0];
            act_two = (|prod_two[PROD_W-1:ACT_W]) ? '1 : prod_two[ACT_W-1:0];
        end
    end

    // ---------------- output register ----------------
    report_kind_t out_kind_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && mid_valid_reg)
        begin
            out_kind_reg <= mid_kind_reg;
            out_data_reg <= {act_two, act_one, mid_total_two_reg,
                             mid_total_one_reg, mid_count_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_tick_clears_totals: assert property (@(posedge clk) disable iff (!rst_n)
        (b_fire && (in_kind_reg == KIND_TICK)) |=>
            ((accum_one_reg == '0) && (accum_two_reg == '0)))
        else $error("totals not cleared after window report");

    a_key_after_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (key_match_reg != KEY_NONE) |-> semicolon_seen_reg)
        else $error("count key matched before separator");

    a_number_after_key: assert property (@(posedge clk) disable iff (!rst_n)
        (number_phase_reg != NUM_START) |-> (key_match_reg == KEY_FOUND))
        else $error("number scan started without count key");

    a_activity_only_on_report: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != RK_WINDOW)) |->
            (m_axis_tdata[OUT_DATA_W-1:3*TOTAL_W] == '0))
        else $error("activity on a line result");

    a_report_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid_reg && (mid_kind_reg == RK_WINDOW)) |-> (mid_count_reg == '0))
        else $error("window report carries a count");

endmodule

[bench/node_count_line_parser_tb.sv]
`timescale 1ns / 1ps

module node_count_line_parser_tb;
    import nclp_pkg::*;

    localparam int ITEM_QUOTA   = 1600;  // nominal size of the random traffic
    localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int HOLD_CYCLES  = 120;   // long receiver stall that backs up the pipeline
    localparam int DRAIN_CYCLES = 6;     // lets the pipeline registers drain with margin

    // One report as it leaves the block, unpacked into its fields
    typedef struct packed {
        report_kind_t kind;
        total_t       count;
        total_t       one;
        total_t       two;
        activity_t    act_one;
        activity_t    act_two;
    } line_report_t;

    // Line parser and window totals mirrored in the testbench, plus the queue
    // of reports that the block still owes.
    class report_scoreboard;
        logic [SCALE_W-1:0] scale;
        logic [7:0]         hello_word [5];
        bit                 nonblank;
        bit                 semi;
        bit                 has_one;
        bit                 has_two;
        logic [2:0]         hello_pos;
        logic [1:0]         key_pos;
        logic [1:0]         num_phase;
        bit                 negative;
        logic [63:0]        magnitude;
        total_t             acc_one;
        total_t             acc_two;
        line_report_t       owed_reports [$];
        int                 errors;
        int                 checked;
        int                 kind_seen [7];

        function new();
            scale = SCALE_RESET;
            hello_word = '{CH_H, CH_E, CH_L, CH_L, CH_O};
            acc_one = '0;
            acc_two = '0;
            errors = 0;
            checked = 0;
            clear_line();
        endfunction

        function void clear_line();
            nonblank = 1'b0;
            semi = 1'b0;
            has_one = 1'b0;
            has_two = 1'b0;
            hello_pos = '0;
            key_pos = KEY_NONE;
            num_phase = NUM_START;
            negative = 1'b0;
            magnitude = '0;
        endfunction

        // Total times scale in Q32.16, clamped to the 48-bit field
        function activity_t activity(total_t total);
            logic [55:0] product;
            product = 56'(total) * 56'(scale);
            return (product[55:48] != '0) ? '1 : product[47:0];
        endfunction

        // Advance the parser by one accepted item; queue the report it causes
        function void note_item(logic kind, logic [7:0] ch);
            line_report_t r;
            logic [63:0]  lim;
            bit           digit;
            r = '0;
            lim = 64'd1 << (COUNT_WIDTH_DEF - 1);
            if (kind == KIND_TICK) begin
                r.kind = RK_WINDOW;
                r.one = acc_one;
                r.two = acc_two;
                r.act_one = activity(acc_one);
                r.act_two = activity(acc_two);
                acc_one = '0;
                acc_two = '0;
                owed_reports.push_back(r);
                return;
            end
            if (ch != CH_LF && ch != CH_CR) begin
                // drop control and high bytes without touching the line
                if (ch < CH_SPACE || ch > CH_TILDE)
                    return;
                digit = (ch >= CH_ZERO && ch <= CH_NINE);
                if (ch != CH_SPACE)
                    nonblank = 1'b1;
                if (hello_pos < HELLO_FOUND)
                    hello_pos = (ch == hello_word[hello_pos]) ? hello_pos + 3'd1 :
                                (ch == CH_H) ? 3'd1 : 3'd0;
                if (!semi) begin
                    if (ch == CH_SEMI)
                        semi = 1'b1;
                    else if (ch == CH_ONE)
                        has_one = 1'b1;
                    else if (ch == CH_TWO)
                        has_two = 1'b1;
                end
                else if (key_pos == KEY_FOUND) begin
                    case (num_phase)
                        NUM_START:
                        begin
                            if (ch == CH_PLUS || ch == CH_MINUS) begin
                                negative = (ch == CH_MINUS);
                                num_phase = NUM_SIGN;
                            end
                            else if (digit) begin
                                magnitude = 64'(ch - CH_ZERO);
                                num_phase = NUM_DIGIT;
                            end
                            else if (ch != CH_SPACE) begin
                                num_phase = NUM_DONE;
                            end
                        end
                        NUM_SIGN, NUM_DIGIT:
                        begin
                            if (digit) begin
                                magnitude = magnitude * 64'd10 + 64'(ch - CH_ZERO);
                                if (magnitude > lim)
                                    magnitude = lim;
                                num_phase = NUM_DIGIT;
                            end
                            else begin
                                num_phase = NUM_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (key_pos == KEY_C && ch == CH_EQUAL) begin
                    key_pos = KEY_FOUND;
                end
                else begin
                    key_pos = (ch == CH_C) ? KEY_C : KEY_NONE;
                end
                return;
            end
            // line end: blank lines vanish, everything else reports once
            if (!nonblank) begin
                clear_line();
                return;
            end
            if (hello_pos == HELLO_FOUND && semi)
                r.kind = RK_HELLO;
            else if (!semi)
                r.kind = RK_NO_SEP;
            else if (key_pos != KEY_FOUND)
                r.kind = RK_NO_KEY;
            else begin
                r.count = negative ? total_t'(64'd0 - magnitude) :
                          total_t'((magnitude > lim - 1) ? lim - 1 : magnitude);
                if (has_one) begin
                    acc_one += r.count;
                    r.kind = RK_NODE_ONE;
                end
                else if (has_two) begin
                    acc_two += r.count;
                    r.kind = RK_NODE_TWO;
                end
                else begin
                    r.kind = RK_UNKNOWN;
                end
            end
            r.one = acc_one;
            r.two = acc_two;
            owed_reports.push_back(r);
            clear_line();
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
        endfunction

        // Match one accepted output item against the oldest owed report
        function void check_result(logic [KIND_W-1:0] kind, logic [OUT_DATA_W-1:0] data);
            line_report_t want;
            if (owed_reports.size() == 0) begin
                errors++;
                $display("%0t: report with none expected, actual kind %0d data 0x%0h",
                         $time, kind, data);
                return;
            end
            want = owed_reports.pop_front();
            checked++;
            kind_seen[want.kind]++;
            compare_field("report_kind", want.kind, kind);
            compare_field("parsed_count", want.count, data[31:0]);
            compare_field("total_one", want.one, data[63:32]);
            compare_field("total_two", want.two, data[95:64]);
            compare_field("activity_one", want.act_one, data[143:96]);
            compare_field("activity_two", want.act_two, data[191:144]);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [SCALE_W-1:0]    cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] rx_byte
    logic                  s_axis_tuser = 1'b0; // [0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [31:0] parsed_count, [63:32] total_one, [95:64] total_two,
    // [143:96] activity_one, [191:144] activity_two
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;        // [2:0] report_kind

    report_scoreboard board;
    logic [7:0]       line_bytes [$];  // bytes of the line being assembled
    bit               no_idle = 1'b0;  // both sides run back to back while set
    bit               hold_request = 1'b0;
    int               holds_done = 0;
    int               items_sent = 0;
    int               scale_settings = 1;
    int               quiet_cycles = 0;

    node_count_line_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Abort when neither side has moved an item for too long
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("node_count_line_parser verification failed");
            $finish;
        end
    end

    // Offer one item, optionally after a random gap, and hold it until taken.
    // Keep tvalid high across back-to-back items instead of toggling it.
    task automatic send_item(input logic kind, input logic [7:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= value;
        s_axis_tuser <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_item(kind, value);
        // count only items the block acts on
        if (kind == KIND_TICK || value == CH_CR || value == CH_LF ||
            (value >= CH_SPACE && value <= CH_TILDE))
            items_sent++;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_bytes.push_back(s[i]);
    endfunction

    function automatic void add_random_text(input int n);
        repeat (n) line_bytes.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
    endfunction

    // Send the assembled line; optionally slip a window end into the middle
    task automatic send_line(input bit mid_tick);
        int cut;
        cut = mid_tick ? $urandom_range(0, line_bytes.size() - 1) : -1;
        foreach (line_bytes[i]) begin
            if (i == cut)
                send_tick();
            send_item(KIND_BYTE, line_bytes[i]);
        end
        line_bytes.delete();
    endtask

    task automatic send_text_line(input string s, input logic [7:0] term);
        add_text(s);
        line_bytes.push_back(term);
        send_line(1'b0);
    endtask

    // Change the scale only once every owed report is back and the pipe is empty
    task automatic write_scale(input logic [SCALE_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.owed_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.scale = value;
        scale_settings++;
    endtask

    // Mostly well-formed measurement lines with random ids, keys, signs and
    // digit runs; the rest are handshakes, blank lines and raw byte noise.
    task automatic run_random(input int quota);
        int    start;
        int    pick;
        string id_pool;
        start = items_sent;
        id_pool = "ABNXZ_-";
        while (items_sent - start < quota) begin
            no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                add_random_text($urandom_range(0, 3));
                add_text(($urandom_range(0, 4) == 0) ? "HELO" : "HELLO");
                add_random_text($urandom_range(0, 3));
                if ($urandom_range(0, 5) != 0)
                    line_bytes.push_back(CH_SEMI);
                add_random_text($urandom_range(0, 4));
            end
            else if (pick < 75) begin
                repeat ($urandom_range(0, 3)) begin
                    case ($urandom_range(0, 3))
                        0: line_bytes.push_back(CH_ONE);
                        1: line_bytes.push_back(CH_TWO);
                        default: line_bytes.push_back(id_pool[$urandom_range(0, id_pool.len() - 1)]);
                    endcase
                end
                if ($urandom_range(0, 19) != 0)
                    line_bytes.push_back(CH_SEMI);
                add_random_text($urandom_range(0, 2));
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    add_text("C-");
                else if (pick != 1)
                    add_text("C=");
                repeat ($urandom_range(0, 2)) line_bytes.push_back(CH_SPACE);
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    line_bytes.push_back(CH_MINUS);
                else if (pick == 1)
                    line_bytes.push_back(CH_PLUS);
                // long digit runs push the count into saturation
                repeat (($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 5))
                    line_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    add_random_text($urandom_range(1, 3));
                if ($urandom_range(0, 4) == 0)
                    line_bytes.push_back(8'($urandom_range(0, 31)));
            end
            else if (pick < 85) begin
                repeat ($urandom_range(0, 3)) line_bytes.push_back(CH_SPACE);
            end
            else begin
                repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            line_bytes.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
            if ($urandom_range(0, 5) == 0)
                line_bytes.push_back(CH_LF);
            send_line($urandom_range(0, 29) == 0);
            if ($urandom_range(0, 9) == 0)
                send_tick();
        end
    endtask

    // Receiver: check every accepted report, then stall for a random number
    // of cycles; on request, hold off long enough to back up the whole pipe.
    initial begin : report_sink
        int stall;
        stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                board.check_result(m_axis_tuser, m_axis_tdata);
                stall = no_idle ? 0 : $urandom_range(0, 5);
            end
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at the reset scale
        send_text_line("HELLO;", CH_LF);             // handshake
        send_text_line("   ", CH_CR);                // spaces only: no report
        send_text_line("", CH_LF);                   // empty line: no report
        send_text_line("HELLO", CH_LF);              // handshake word without separator
        send_text_line("N1;C=123", CH_LF);
        send_text_line("N2;C=-45", CH_CR);
        send_text_line("N12;C=7", CH_LF);            // both digits: node one wins
        send_text_line("X;C=9", CH_LF);              // unknown node
        send_text_line("N1;T=5", CH_LF);             // no count key
        send_text_line("N2;C=", CH_LF);              // key with no digits counts zero
        send_text_line("N1;C=99999999999", CH_LF);   // positive saturation
        send_text_line("N2;C=-99999999999", CH_LF);  // negative saturation
        send_text_line("N1;xCC= +42x", CH_LF);       // repeated C, space, plus sign
        send_text_line("HEHELLO ~;", CH_LF);         // handshake match restarts on H
        // drop control and high bytes inside a line
        add_text("N2;C=1");
        line_bytes.push_back(8'h00);
        line_bytes.push_back(8'h7f);
        line_bytes.push_back(8'hff);
        line_bytes.push_back(8'h09);
        add_text("5");
        line_bytes.push_back(CH_LF);
        send_line(1'b0);
        // window end in the middle of a line keeps the partial line
        add_text("N1;C=");
        send_line(1'b0);
        send_tick();
        send_text_line("8", CH_LF);
        send_tick();

        run_random(ITEM_QUOTA / 5);

        // Back up the pipeline: stall the receiver while offering dense traffic
        hold_request = 1'b1;
        no_idle = 1'b1;
        repeat (12) begin
            send_text_line("N2;C=3", CH_LF);
            send_tick();
        end

        write_scale('0);
        run_random(ITEM_QUOTA / 6);

        // Largest scale with large totals forces activity saturation
        write_scale('1);
        send_text_line("N1;C=2147483647", CH_LF);
        send_text_line("N2;C=-1", CH_LF);
        send_tick();
        run_random(ITEM_QUOTA / 6);

        write_scale(SCALE_W'(1));
        run_random(ITEM_QUOTA / 8);

        repeat (3) begin
            write_scale(SCALE_W'($urandom()));
            run_random(ITEM_QUOTA / 8);
        end

        // Wait out the owed reports, then let the pipeline drain for strays
        s_axis_tvalid <= 1'b0;
        while (board.owed_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items, checked %0d reports over %0d scale settings, %0d long stall(s).",
                 items_sent, board.checked, scale_settings, holds_done);
        $display("Reports: hello %0d, one %0d, two %0d, unknown %0d, no sep %0d, no key %0d, window %0d",
                 board.kind_seen[RK_HELLO], board.kind_seen[RK_NODE_ONE],
                 board.kind_seen[RK_NODE_TWO], board.kind_seen[RK_UNKNOWN],
                 board.kind_seen[RK_NO_SEP], board.kind_seen[RK_NO_KEY],
                 board.kind_seen[RK_WINDOW]);
        if (board.errors == 0 && board.owed_reports.size() == 0)
            $display("node_count_line_parser verification clean");
        else
            $display("node_count_line_parser verification failed");
        $finish;
    end

endmodule
